>>> rtl/core/prq_pkg.sv
// Shared types, constants and helpers of the priority run queue.
`timescale 1ns / 1ps
package prq_pkg;

  localparam int PRIO_TOP = 31;
  localparam int LEVELS   = PRIO_TOP + 1;
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int THREADS  = 64;
  localparam int TID_W    = $clog2(THREADS);
  localparam int LINK_W   = TID_W + 1;
  localparam int CNT_W    = $clog2(THREADS + 1);

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(THREADS);

  // command codes
  localparam logic [3:0] MODE_INIT    = 4'd0;
  localparam logic [3:0] MODE_RUN     = 4'd1;
  localparam logic [3:0] MODE_SETBASE = 4'd2;
  localparam logic [3:0] MODE_BUMP    = 4'd3;
  localparam logic [3:0] MODE_UYIELD  = 4'd4;
  localparam logic [3:0] MODE_YIELD   = 4'd5;
  localparam logic [3:0] MODE_PREEMPT = 4'd6;
  localparam logic [3:0] MODE_REMOVE  = 4'd7;
  localparam logic [3:0] MODE_NEXT    = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;

  // config register indexes
  localparam logic CFG_TICK = 1'b0;
  localparam logic CFG_IDLE = 1'b1;

  typedef struct packed {
    logic [3:0] mode;
    logic [5:0] thread_id;
    logic [5:0] new_priority;
    logic       round_robin;
    logic [4:0] current_priority;
    logic       current_is_posix;
  } prq_in_t;

  typedef struct packed {
    logic       resched;
    logic [5:0] next_thread;
    logic       next_valid;
    logic [1:0] status;
    logic [6:0] ready_count;
  } prq_out_t;

  // per-thread memory word
  typedef struct packed {
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
    logic              onq;
    logic [LVL_W-1:0]  prio;
    logic [LVL_W-1:0]  base;
    logic [7:0]        ticks;
    logic              rr;
  } thr_ent_t;

  // per-level memory word
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } lvl_ent_t;

  localparam thr_ent_t THR_RESET = '{nxt: LINK_NONE, prv: LINK_NONE, onq: 1'b0,
                                     prio: '0, base: '0, ticks: '0, rr: 1'b0};
  localparam lvl_ent_t LVL_RESET = '{head: LINK_NONE, tail: LINK_NONE};

  function automatic logic [LVL_W-1:0] sat_prio(input logic [5:0] np);
    sat_prio = (32'(np) > PRIO_TOP) ? LVL_W'(PRIO_TOP) : np[LVL_W-1:0];
  endfunction

  // highest set bit of the level bitmap
  function automatic logic [LVL_W-1:0] top_level(input logic [LEVELS-1:0] bm);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bm[i]) r = LVL_W'(i);
    end
    top_level = r;
  endfunction

endpackage

>>> rtl/core/prq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/prq_ctrl.sv
// Command sequencer: thread and level memories, list edits, bitmap and count.
`timescale 1ns / 1ps
module prq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  prq_pkg::prq_in_t  cmd,
  input  logic [7:0]        tick_reload,
  input  logic [5:0]        idle_id,
  input  logic              res_take,
  output logic              idle,
  output logic              done,
  output prq_pkg::prq_out_t res
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001, S_NXL = 15'h0002, S_DEC = 15'h0004, S_UL  = 15'h0008,
    S_UL2  = 15'h0010, S_UP  = 15'h0020, S_UN0 = 15'h0040, S_UN  = 15'h0080,
    S_UFIN = 15'h0100, S_P0  = 15'h0200, S_P1  = 15'h0400, S_P2  = 15'h0800,
    S_P3   = 15'h1000, S_WT  = 15'h2000, S_DONE = 15'h4000
  } state_t;

  localparam int TW = $bits(prq_pkg::thr_ent_t);
  localparam int LW = $bits(prq_pkg::lvl_ent_t);

  state_t state_r, state_nxt;
  prq_pkg::prq_in_t cmd_r, cmd_nxt;
  logic [prq_pkg::TID_W-1:0] t_r, t_nxt, nb_r, nb_nxt;
  prq_pkg::thr_ent_t cur_r, cur_nxt;
  prq_pkg::lvl_ent_t lvl_r, lvl_nxt;
  logic [prq_pkg::LVL_W-1:0] newp_r, newp_nxt;
  logic requeue_r, requeue_nxt, puthead_r, puthead_nxt, check_r, check_nxt;
  logic [1:0] status_r, status_nxt;
  logic [5:0] nt_r, nt_nxt;
  logic nv_r, nv_nxt;
  logic [prq_pkg::LEVELS-1:0] bitmap_r, bitmap_nxt;
  logic [prq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [prq_pkg::THREADS-1:0] tv_r;
  logic [prq_pkg::LEVELS-1:0] lv_r;
  logic tvh_r, lvh_r;

  // memory ports
  logic t_we, t_re, l_we, l_re;
  logic [prq_pkg::TID_W-1:0] t_waddr, t_raddr;
  logic [prq_pkg::LVL_W-1:0] l_waddr, l_raddr;
  prq_pkg::thr_ent_t t_wdata, t_dout, tdat;
  prq_pkg::lvl_ent_t l_wdata, l_dout, ldat;
  logic [TW-1:0] t_q;
  logic [LW-1:0] l_q;

  prq_ram #(.WIDTH(TW), .DEPTH(prq_pkg::THREADS)) u_thr_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_q)
  );

  prq_ram #(.WIDTH(LW), .DEPTH(prq_pkg::LEVELS)) u_lvl_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_q)
  );

  // entries never written read as their reset value
  assign t_dout = prq_pkg::thr_ent_t'(t_q);
  assign l_dout = prq_pkg::lvl_ent_t'(l_q);
  assign tdat = tvh_r ? t_dout : prq_pkg::THR_RESET;
  assign ldat = lvh_r ? l_dout : prq_pkg::LVL_RESET;

  logic [prq_pkg::LVL_W-1:0] np_sat, top_p;
  logic [prq_pkg::LINK_W-1:0] old_l;
  logic [7:0] tk_dec;
  logic is_disp;

  assign np_sat  = prq_pkg::sat_prio(cmd_r.new_priority);
  assign top_p   = prq_pkg::top_level(bitmap_r);
  assign old_l   = puthead_r ? ldat.head : ldat.tail;
  assign tk_dec  = tdat.ticks - 8'd1;
  assign is_disp = (cmd_r.mode == prq_pkg::MODE_UYIELD) || (cmd_r.mode == prq_pkg::MODE_YIELD)
                || (cmd_r.mode == prq_pkg::MODE_PREEMPT);

  // sequencer
  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; t_nxt = t_r; nb_nxt = nb_r;
    cur_nxt = cur_r; lvl_nxt = lvl_r; newp_nxt = newp_r;
    requeue_nxt = requeue_r; puthead_nxt = puthead_r; check_nxt = check_r;
    status_nxt = status_r; nt_nxt = nt_r; nv_nxt = nv_r;
    bitmap_nxt = bitmap_r; count_nxt = count_r;
    t_we = 1'b0; t_re = 1'b0; l_we = 1'b0; l_re = 1'b0;
    t_waddr = nb_r; t_raddr = cmd.thread_id; l_waddr = cur_r.prio; l_raddr = cur_r.prio;
    t_wdata = cur_r; l_wdata = lvl_r;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd; t_nxt = cmd.thread_id;
          status_nxt = prq_pkg::ST_OK; nt_nxt = '0; nv_nxt = 1'b0; check_nxt = 1'b0;
          if (cmd.mode == prq_pkg::MODE_NEXT) begin
            if (bitmap_r != '0) begin
              l_re = 1'b1; l_raddr = top_p; state_nxt = S_NXL;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (cmd.mode > prq_pkg::MODE_NEXT) begin
            state_nxt = S_DONE;
          end else begin
            t_re = 1'b1; state_nxt = S_DEC;
          end
        end
      end
      S_NXL: begin
        t_nxt = ldat.head[prq_pkg::TID_W-1:0];
        t_re = 1'b1; t_raddr = ldat.head[prq_pkg::TID_W-1:0];
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cur_nxt = tdat; requeue_nxt = 1'b0; state_nxt = S_DONE;
        if (cmd_r.mode == prq_pkg::MODE_NEXT) begin
          nt_nxt = t_r; nv_nxt = 1'b1; state_nxt = S_UL;
        end else if (is_disp && cmd_r.thread_id == idle_id) begin
          status_nxt = prq_pkg::ST_IDLE;
        end else if ((is_disp || cmd_r.mode == prq_pkg::MODE_INIT
                      || cmd_r.mode == prq_pkg::MODE_RUN) && tdat.onq) begin
          status_nxt = prq_pkg::ST_QUEUED;
        end else begin
          case (cmd_r.mode)
            prq_pkg::MODE_INIT: begin
              cur_nxt.rr = cmd_r.round_robin; cur_nxt.base = np_sat;
              cur_nxt.prio = np_sat; cur_nxt.ticks = tick_reload;
              state_nxt = S_WT;
            end
            prq_pkg::MODE_RUN: begin
              puthead_nxt = 1'b0; check_nxt = 1'b1; state_nxt = S_P0;
            end
            prq_pkg::MODE_UYIELD: begin
              puthead_nxt = 1'b0; state_nxt = S_P0;
            end
            prq_pkg::MODE_YIELD: begin
              puthead_nxt = 1'b1; state_nxt = S_P0;
            end
            prq_pkg::MODE_PREEMPT: begin
              state_nxt = S_P0; puthead_nxt = 1'b1;
              if (tdat.rr) begin
                if (tk_dec == 8'd0) begin
                  cur_nxt.ticks = tick_reload; puthead_nxt = 1'b0;
                end else begin
                  cur_nxt.ticks = tk_dec;
                end
              end
            end
            prq_pkg::MODE_SETBASE: begin
              if (tdat.base != np_sat) begin
                cur_nxt.base = np_sat; newp_nxt = np_sat; check_nxt = 1'b1;
                if (tdat.onq) begin
                  requeue_nxt = 1'b1; state_nxt = S_UL;
                end else begin
                  cur_nxt.prio = np_sat; state_nxt = S_WT;
                end
              end
            end
            prq_pkg::MODE_BUMP: begin
              if ({1'b0, tdat.prio} != cmd_r.new_priority) begin
                newp_nxt = np_sat; check_nxt = 1'b1;
                if (tdat.onq) begin
                  requeue_nxt = 1'b1; state_nxt = S_UL;
                end else begin
                  cur_nxt.prio = np_sat; state_nxt = S_WT;
                end
              end
            end
            prq_pkg::MODE_REMOVE: begin
              if (tdat.onq) state_nxt = S_UL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // unlink: read the level, patch both neighbors, write the level back
      S_UL: begin
        l_re = 1'b1; state_nxt = S_UL2;
      end
      S_UL2: begin
        lvl_nxt = ldat;
        if (cur_r.prv != prq_pkg::LINK_NONE) begin
          t_re = 1'b1; t_raddr = cur_r.prv[prq_pkg::TID_W-1:0];
          nb_nxt = cur_r.prv[prq_pkg::TID_W-1:0]; state_nxt = S_UP;
        end else begin
          lvl_nxt.head = cur_r.nxt; state_nxt = S_UN0;
        end
      end
      S_UP: begin
        t_we = 1'b1; t_wdata = tdat; t_wdata.nxt = cur_r.nxt; state_nxt = S_UN0;
      end
      S_UN0: begin
        if (cur_r.nxt != prq_pkg::LINK_NONE) begin
          t_re = 1'b1; t_raddr = cur_r.nxt[prq_pkg::TID_W-1:0];
          nb_nxt = cur_r.nxt[prq_pkg::TID_W-1:0]; state_nxt = S_UN;
        end else begin
          lvl_nxt.tail = cur_r.prv; state_nxt = S_UFIN;
        end
      end
      S_UN: begin
        t_we = 1'b1; t_wdata = tdat; t_wdata.prv = cur_r.prv; state_nxt = S_UFIN;
      end
      S_UFIN: begin
        l_we = 1'b1;
        if (lvl_r.head == prq_pkg::LINK_NONE) bitmap_nxt[cur_r.prio] = 1'b0;
        count_nxt = count_r - 1'b1;
        cur_nxt.nxt = prq_pkg::LINK_NONE; cur_nxt.prv = prq_pkg::LINK_NONE;
        cur_nxt.onq = 1'b0;
        if (requeue_r) begin
          cur_nxt.prio = newp_r; puthead_nxt = 1'b0; state_nxt = S_P0;
        end else begin
          state_nxt = S_WT;
        end
      end
      // enqueue at head or tail of the thread's level
      S_P0: begin
        l_re = 1'b1; state_nxt = S_P1;
      end
      S_P1: begin
        lvl_nxt = ldat;
        if (puthead_r) begin
          cur_nxt.prv = prq_pkg::LINK_NONE; cur_nxt.nxt = old_l;
        end else begin
          cur_nxt.nxt = prq_pkg::LINK_NONE; cur_nxt.prv = old_l;
        end
        if (old_l != prq_pkg::LINK_NONE) begin
          t_re = 1'b1; t_raddr = old_l[prq_pkg::TID_W-1:0];
          nb_nxt = old_l[prq_pkg::TID_W-1:0]; state_nxt = S_P2;
        end else begin
          state_nxt = S_P3;
        end
      end
      S_P2: begin
        t_we = 1'b1; t_wdata = tdat;
        if (puthead_r) t_wdata.prv = {1'b0, t_r};
        else t_wdata.nxt = {1'b0, t_r};
        state_nxt = S_P3;
      end
      S_P3: begin
        l_we = 1'b1;
        if (puthead_r) begin
          l_wdata.head = {1'b0, t_r};
          l_wdata.tail = (lvl_r.head == prq_pkg::LINK_NONE) ? {1'b0, t_r} : lvl_r.tail;
        end else begin
          l_wdata.tail = {1'b0, t_r};
          l_wdata.head = (lvl_r.tail == prq_pkg::LINK_NONE) ? {1'b0, t_r} : lvl_r.head;
        end
        bitmap_nxt[cur_r.prio] = 1'b1;
        count_nxt = count_r + 1'b1;
        cur_nxt.onq = 1'b1;
        state_nxt = S_WT;
      end
      S_WT: begin
        t_we = 1'b1; t_waddr = t_r; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          done = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bitmap_r <= '0;
      count_r <= '0;
      tv_r <= '0;
      lv_r <= '0;
    end else begin
      state_r <= state_nxt;
      bitmap_r <= bitmap_nxt;
      count_r <= count_nxt;
      if (t_we) tv_r[t_waddr] <= 1'b1;
      if (l_we) lv_r[l_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; t_r <= t_nxt; nb_r <= nb_nxt; cur_r <= cur_nxt; lvl_r <= lvl_nxt;
    newp_r <= newp_nxt; requeue_r <= requeue_nxt; puthead_r <= puthead_nxt;
    check_r <= check_nxt; status_r <= status_nxt; nt_r <= nt_nxt; nv_r <= nv_nxt;
    if (t_re) tvh_r <= tv_r[t_raddr];
    if (l_re) lvh_r <= lv_r[l_raddr];
  end

  // result word
  assign idle = (state_r == S_IDLE);
  always_comb begin
    res.resched = check_r && cmd_r.current_is_posix && (bitmap_r != '0)
               && (cmd_r.current_priority < top_p);
    res.next_thread = nt_r;
    res.next_valid  = nv_r;
    res.status      = status_r;
    res.ready_count = 7'(count_r);
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= prq_pkg::THREADS) else $error("ready count overflow");
  a_bitmap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (bitmap_r == '0) == (count_r == '0)) else $error("bitmap and count disagree");
  a_enq_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_P3 |=> bitmap_r[$past(cur_r.prio)]) else $error("enqueue left level clear");

endmodule

>>> rtl/core/priority_fifo_rr_run_queue_top.sv
// Top level of the priority run queue: config registers, result register.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall   | in_data (prq_in_t)
//  out     | output    | out_valid/out_stall | out_data (prq_out_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// The thread and level memories each give one read a cycle through a registered
// read port, and every list edit is a read then write.
// Reset is synchronous, active low; the queue is empty afterwards, no sweep.
// The next beat is taken while a result waits in the output register.
`timescale 1ns / 1ps
module priority_fifo_rr_run_queue_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  prq_pkg::prq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output prq_pkg::prq_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0] tick_reload_r;
  logic [5:0] idle_id_r;
  logic out_valid_r;
  prq_pkg::prq_out_t out_r, res;
  logic idle, done, res_take;

  assign in_stall = !idle;
  assign res_take = !out_valid_r || !out_stall;

  prq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid && idle), .cmd(in_data),
    .tick_reload(tick_reload_r), .idle_id(idle_id_r), .res_take(res_take),
    .idle(idle), .done(done), .res(res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_reload_r <= 8'd10;
      idle_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        prq_pkg::CFG_TICK: tick_reload_r <= cfg_wdata;
        prq_pkg::CFG_IDLE: idle_id_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench of the priority run queue: random and directed beats.
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  prq_pkg::prq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  prq_pkg::prq_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_index = prq_pkg::CFG_TICK;
  logic [7:0] cfg_wdata = '0;

  priority_fifo_rr_run_queue_top u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #4 clk = ~clk;

  // mirror of the queue state
  logic [prq_pkg::LINK_W-1:0] lv_head [prq_pkg::LEVELS];
  logic [prq_pkg::LINK_W-1:0] lv_tail [prq_pkg::LEVELS];
  logic [prq_pkg::LINK_W-1:0] th_next [prq_pkg::THREADS];
  logic [prq_pkg::LINK_W-1:0] th_prev [prq_pkg::THREADS];
  logic              th_onq  [prq_pkg::THREADS];
  logic [4:0]        th_prio [prq_pkg::THREADS];
  logic [4:0]        th_base [prq_pkg::THREADS];
  logic [7:0]        th_ticks[prq_pkg::THREADS];
  logic              th_rr   [prq_pkg::THREADS];
  logic [prq_pkg::LEVELS-1:0] lv_busy;
  int                n_ready;
  logic [7:0]        slice_reload;
  logic [5:0]        idle_tid;

  prq_pkg::prq_in_t  cmd_q[$];
  prq_pkg::prq_out_t want_q[$];
  bit       known_tid[prq_pkg::THREADS];
  int       err_cnt = 0;
  bit       quiet = 1'b0;
  bit       took = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       dead_cycles = 0;

  function automatic int highest_level();
    for (int p = prq_pkg::PRIO_TOP; p >= 0; p--) if (lv_busy[p]) return p;
    return -1;
  endfunction

  function automatic void link_tail(int t);
    int p;
    p = int'(th_prio[t]);
    th_next[t] = prq_pkg::LINK_NONE;
    th_prev[t] = lv_tail[p];
    if (lv_tail[p] != prq_pkg::LINK_NONE) th_next[lv_tail[p]] = prq_pkg::LINK_W'(t);
    else lv_head[p] = prq_pkg::LINK_W'(t);
    lv_tail[p] = prq_pkg::LINK_W'(t);
    lv_busy[p] = 1'b1;
    th_onq[t] = 1'b1;
    n_ready++;
  endfunction

  function automatic void link_head(int t);
    int p;
    p = int'(th_prio[t]);
    th_prev[t] = prq_pkg::LINK_NONE;
    th_next[t] = lv_head[p];
    if (lv_head[p] != prq_pkg::LINK_NONE) th_prev[lv_head[p]] = prq_pkg::LINK_W'(t);
    else lv_tail[p] = prq_pkg::LINK_W'(t);
    lv_head[p] = prq_pkg::LINK_W'(t);
    lv_busy[p] = 1'b1;
    th_onq[t] = 1'b1;
    n_ready++;
  endfunction

  function automatic void unlink(int t);
    int p;
    p = int'(th_prio[t]);
    if (th_prev[t] != prq_pkg::LINK_NONE) th_next[th_prev[t]] = th_next[t];
    else lv_head[p] = th_next[t];
    if (th_next[t] != prq_pkg::LINK_NONE) th_prev[th_next[t]] = th_prev[t];
    else lv_tail[p] = th_prev[t];
    th_next[t] = prq_pkg::LINK_NONE;
    th_prev[t] = prq_pkg::LINK_NONE;
    th_onq[t] = 1'b0;
    n_ready--;
    if (lv_head[p] == prq_pkg::LINK_NONE) lv_busy[p] = 1'b0;
  endfunction

  function automatic void move_level(int t, logic [4:0] p);
    if (th_onq[t]) begin
      unlink(t);
      th_prio[t] = p;
      link_tail(t);
    end else begin
      th_prio[t] = p;
    end
  endfunction

  function automatic logic [4:0] clamp_prio(logic [5:0] v);
    return (v > prq_pkg::PRIO_TOP) ? 5'(prq_pkg::PRIO_TOP) : v[4:0];
  endfunction

  // result of one command, updating the mirror
  function automatic prq_pkg::prq_out_t schedule_cmd(prq_pkg::prq_in_t c);
    prq_pkg::prq_out_t r;
    int t;
    int p;
    bit eval;
    r = '0;
    t = int'(c.thread_id);
    eval = 1'b0;
    if (c.mode == prq_pkg::MODE_NEXT) begin
      p = highest_level();
      if (p >= 0) begin
        r.next_thread = lv_head[p][5:0];
        r.next_valid = 1'b1;
        unlink(int'(lv_head[p]));
      end
    end else if (c.mode <= prq_pkg::MODE_REMOVE) begin
      if (c.mode inside {prq_pkg::MODE_UYIELD, prq_pkg::MODE_YIELD, prq_pkg::MODE_PREEMPT}
          && c.thread_id == idle_tid)
        r.status = prq_pkg::ST_IDLE;
      else if (c.mode inside {prq_pkg::MODE_INIT, prq_pkg::MODE_RUN, prq_pkg::MODE_UYIELD,
                              prq_pkg::MODE_YIELD, prq_pkg::MODE_PREEMPT}
               && th_onq[t])
        r.status = prq_pkg::ST_QUEUED;
      else begin
        case (c.mode)
          prq_pkg::MODE_INIT: begin
            th_rr[t] = c.round_robin;
            th_base[t] = clamp_prio(c.new_priority);
            th_prio[t] = clamp_prio(c.new_priority);
            th_ticks[t] = slice_reload;
          end
          prq_pkg::MODE_RUN: begin
            link_tail(t);
            eval = 1'b1;
          end
          prq_pkg::MODE_SETBASE: begin
            if (th_base[t] != clamp_prio(c.new_priority)) begin
              th_base[t] = clamp_prio(c.new_priority);
              move_level(t, clamp_prio(c.new_priority));
              eval = 1'b1;
            end
          end
          prq_pkg::MODE_BUMP: begin
            // compare against the unclamped value
            if ({1'b0, th_prio[t]} != c.new_priority) begin
              move_level(t, clamp_prio(c.new_priority));
              eval = 1'b1;
            end
          end
          prq_pkg::MODE_UYIELD: link_tail(t);
          prq_pkg::MODE_YIELD:  link_head(t);
          prq_pkg::MODE_PREEMPT: begin
            if (th_rr[t]) begin
              th_ticks[t] = th_ticks[t] - 8'd1;
              if (th_ticks[t] == 8'd0) begin
                link_tail(t);
                th_ticks[t] = slice_reload;
              end else begin
                link_head(t);
              end
            end else begin
              link_head(t);
            end
          end
          default: if (th_onq[t]) unlink(t);
        endcase
      end
    end
    if (eval && c.current_is_posix && int'(c.current_priority) < highest_level())
      r.resched = 1'b1;
    r.ready_count = 7'(n_ready);
    return r;
  endfunction

  task automatic add_cmd(logic [3:0] m, int t, int np, bit rr, int cur, bit px);
    prq_pkg::prq_in_t c;
    c.mode = m;
    c.thread_id = 6'(t);
    c.new_priority = 6'(np);
    c.round_robin = rr;
    c.current_priority = 5'(cur);
    c.current_is_posix = px;
    if (m == prq_pkg::MODE_INIT) known_tid[t] = 1'b1;
    cmd_q.push_back(c);
  endtask

  function automatic int pick_known();
    int t;
    do t = $urandom_range(0, prq_pkg::THREADS - 1); while (!known_tid[t]);
    return t;
  endfunction

  task automatic add_random(int n);
    int w;
    logic [3:0] m;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      if (w < 10) m = prq_pkg::MODE_INIT;
      else if (w < 30) m = prq_pkg::MODE_RUN;
      else if (w < 37) m = prq_pkg::MODE_SETBASE;
      else if (w < 44) m = prq_pkg::MODE_BUMP;
      else if (w < 50) m = prq_pkg::MODE_UYIELD;
      else if (w < 56) m = prq_pkg::MODE_YIELD;
      else if (w < 68) m = prq_pkg::MODE_PREEMPT;
      else if (w < 75) m = prq_pkg::MODE_REMOVE;
      else if (w < 97) m = prq_pkg::MODE_NEXT;
      else m = 4'($urandom_range(9, 15));
      add_cmd(m, (m == prq_pkg::MODE_INIT) ? $urandom_range(0, prq_pkg::THREADS - 1)
                                           : pick_known(),
              $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 31),
              $urandom_range(0, 1));
    end
  endtask

  // wait for the block to drain, then a quiet margin
  task automatic drain();
    while (cmd_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == prq_pkg::CFG_TICK) slice_reload = v;
    else idle_tid = v[5:0];
  endtask

  // stimulus and phase sequencing
  initial begin
    for (int i = 0; i < prq_pkg::LEVELS; i++) begin
      lv_head[i] = prq_pkg::LINK_NONE;
      lv_tail[i] = prq_pkg::LINK_NONE;
    end
    for (int i = 0; i < prq_pkg::THREADS; i++) begin
      th_next[i] = prq_pkg::LINK_NONE;
      th_prev[i] = prq_pkg::LINK_NONE;
      th_onq[i] = 1'b0;
      th_prio[i] = '0;
      th_base[i] = '0;
      th_ticks[i] = '0;
      th_rr[i] = 1'b0;
      known_tid[i] = 1'b0;
    end
    lv_busy = '0;
    n_ready = 0;
    slice_reload = 8'd10;
    idle_tid = 6'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: saturation, equal values, queued and idle refusals, empty dequeue
    add_cmd(prq_pkg::MODE_INIT, 0, 5, 1, 0, 0);
    add_cmd(prq_pkg::MODE_INIT, 1, 63, 1, 0, 0);
    add_cmd(prq_pkg::MODE_INIT, 2, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_INIT, 3, 31, 1, 0, 0);
    add_cmd(prq_pkg::MODE_RUN, 1, 0, 0, 0, 1);
    add_cmd(prq_pkg::MODE_RUN, 1, 0, 0, 0, 1);
    add_cmd(prq_pkg::MODE_RUN, 2, 0, 0, 31, 1);
    add_cmd(prq_pkg::MODE_SETBASE, 2, 0, 0, 0, 1);
    add_cmd(prq_pkg::MODE_SETBASE, 2, 40, 0, 3, 1);
    add_cmd(prq_pkg::MODE_BUMP, 3, 3, 0, 0, 1);
    add_cmd(prq_pkg::MODE_BUMP, 3, 3, 0, 0, 1);
    add_cmd(prq_pkg::MODE_BUMP, 3, 63, 0, 0, 0);
    add_cmd(prq_pkg::MODE_UYIELD, 0, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_YIELD, 3, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_PREEMPT, 2, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_PREEMPT, 0, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_REMOVE, 1, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_REMOVE, 1, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_NEXT, 0, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_NEXT, 0, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_NEXT, 0, 0, 0, 0, 0);
    add_cmd(prq_pkg::MODE_PREEMPT, 3, 0, 0, 0, 0);
    add_cmd(4'd9, 3, 0, 0, 0, 0);
    add_cmd(4'd15, 3, 63, 1, 31, 1);
    add_random(360);
    drain();

    write_reg(prq_pkg::CFG_TICK, 8'd1);
    write_reg(prq_pkg::CFG_IDLE, 8'd63);
    add_random(370);
    drain();

    write_reg(prq_pkg::CFG_TICK, 8'd255);
    write_reg(prq_pkg::CFG_IDLE, 8'($urandom_range(0, 63)));
    add_random(370);
    drain();

    write_reg(prq_pkg::CFG_TICK, 8'd3);
    write_reg(prq_pkg::CFG_IDLE, 8'd0);
    add_random(200);
    while (cmd_q.size() > 0) @(posedge clk);
    quiet = 1'b1;
    add_random(180);
    drain();

    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // input beat acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      want_q.push_back(schedule_cmd(in_data));
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // input driver with random gaps
  always @(negedge clk) begin
    if (!in_valid || took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0 && rst_n) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    prq_pkg::prq_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        w = want_q.pop_front();
        if (out_data.resched !== w.resched) begin
          $error("resched exp %0d got %0d", w.resched, out_data.resched); err_cnt++;
        end
        if (out_data.next_thread !== w.next_thread) begin
          $error("next_thread exp %0d got %0d", w.next_thread, out_data.next_thread);
          err_cnt++;
        end
        if (out_data.next_valid !== w.next_valid) begin
          $error("next_valid exp %0d got %0d", w.next_valid, out_data.next_valid);
          err_cnt++;
        end
        if (out_data.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_data.status); err_cnt++;
        end
        if (out_data.ready_count !== w.ready_count) begin
          $error("ready_count exp %0d got %0d", w.ready_count, out_data.ready_count);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
